@@ rtl/core/assert_macros.svh @@
// assert_macros.svh: shared concurrent assertion macros.
// Used by the checker file of the core, vgu_checker.sv; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication into the next cycle
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/core/vgu_pkg.sv @@
// vgu_pkg: shared types and defaults for the vector geometry unit.
// No dependencies.
`timescale 1ns / 1ps

package vgu_pkg;

    localparam int FIELD_W        = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int COMP_WIDTH_DEF = 32;

    typedef enum logic [1:0] {
        OP_NORM = 2'd0,
        OP_SUB  = 2'd1,
        OP_DOT  = 2'd2,
        OP_DIST = 2'd3
    } t_op;

    typedef struct packed {
        t_op                      operation;
        logic signed [FIELD_W-1:0] ax;
        logic signed [FIELD_W-1:0] ay;
        logic signed [FIELD_W-1:0] az;
        logic signed [FIELD_W-1:0] bx;
        logic signed [FIELD_W-1:0] by;
        logic signed [FIELD_W-1:0] bz;
    } t_in_item;

    typedef struct packed {
        logic signed [FIELD_W-1:0] rx;
        logic signed [FIELD_W-1:0] ry;
        logic signed [FIELD_W-1:0] rz;
        logic signed [FIELD_W-1:0] scalar;
        logic                      overflow;
    } t_out_item;

    // per-stage control travelling alongside the data
    typedef struct packed {
        logic valid;
        t_op  op;
        logic zero;
    } t_ctl;

endpackage

@@ rtl/core/vgu_front.sv @@
// vgu_front: operand prep, three shared multipliers, sums, dot rounding.
// Three register stages. Depends on vgu_pkg.
`timescale 1ns / 1ps

module vgu_front #(
    parameter int FRAC_BITS  = 16,
    parameter int COMP_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  vgu_pkg::t_in_item    i_item,
    output vgu_pkg::t_ctl        o_ctl,
    output logic [2*COMP_WIDTH+1:0] o_sum,
    output logic [4*COMP_WIDTH:0]   o_res
);
    import vgu_pkg::*;

    localparam int W  = COMP_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int SW = 2*W+2;
    localparam int DW = SW+1;
    localparam logic [W-1:0] MAXP = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINN = {1'b1, {(W-1){1'b0}}};
    localparam logic [DW-1:0] HALF = DW'(1) << (F-1);

    typedef struct packed {
        logic [2:0][W-1:0] r;
        logic [W-1:0]      sc;
        logic              ovf;
    } t_res;

    function automatic logic [W:0] mag1(input logic signed [W:0] v);
        mag1 = v[W] ? $unsigned(-v) : $unsigned(v);
    endfunction

    // stage 1
    logic signed [2:0][W-1:0] a, b;
    logic [2:0][W:0]    mx, my;
    logic [2:0]         n_sgn;
    logic [2:0][SW-1:0] n_prod;
    t_res               n_res1;
    logic signed [W:0]  ae, be, de, se;

    always_comb begin
        a[0] = W'($unsigned(i_item.ax));
        a[1] = W'($unsigned(i_item.ay));
        a[2] = W'($unsigned(i_item.az));
        b[0] = W'($unsigned(i_item.bx));
        b[1] = W'($unsigned(i_item.by));
        b[2] = W'($unsigned(i_item.bz));
        n_res1 = '0;
        ae = '0; be = '0; de = '0; se = '0;
        for (int j = 0; j < 3; j++) begin
            ae = {a[j][W-1], a[j]};
            be = {b[j][W-1], b[j]};
            de = be - ae;
            se = ae - be;
            n_sgn[j] = a[j][W-1] ^ b[j][W-1];
            case (i_item.operation)
                OP_NORM: begin
                    mx[j] = mag1(ae);
                    my[j] = mag1(ae);
                    n_res1.r[j] = a[j];
                end
                OP_SUB: begin
                    mx[j] = '0;
                    my[j] = '0;
                    if (se[W] != se[W-1]) begin
                        n_res1.ovf  = 1'b1;
                        n_res1.r[j] = se[W] ? MINN : MAXP;
                    end else begin
                        n_res1.r[j] = se[W-1:0];
                    end
                end
                OP_DOT: begin
                    mx[j] = mag1(ae);
                    my[j] = mag1(be);
                end
                default: begin
                    mx[j] = mag1(de);
                    my[j] = mag1(de);
                end
            endcase
            n_prod[j] = SW'(mx[j]) * SW'(my[j]);
        end
    end

    t_ctl               r_ctl1, r_ctl2, r_ctl3;
    logic [2:0]         r_sgn1;
    logic [2:0][SW-1:0] r_prod1;
    t_res               r_res1, r_res2, r_res3;

    // stage 2: sums
    logic [SW-1:0]        n_sum2;
    logic signed [DW-1:0] n_sd2, t2;
    logic [SW-1:0]        r_sum2, r_sum3;
    logic signed [DW-1:0] r_sd2;

    always_comb begin
        n_sum2 = r_prod1[0] + r_prod1[1] + r_prod1[2];
        n_sd2  = '0;
        t2     = '0;
        for (int j = 0; j < 3; j++) begin
            t2    = $signed({1'b0, r_prod1[j]});
            n_sd2 = r_sgn1[j] ? n_sd2 - t2 : n_sd2 + t2;
        end
    end

    // stage 3: dot rounding and clamp
    logic          neg3;
    logic [DW-1:0] m3, mr3;
    logic [W-1:0]  v3;
    t_res          n_res3;

    always_comb begin
        n_res3 = r_res2;
        neg3   = r_sd2[DW-1];
        m3     = neg3 ? $unsigned(-r_sd2) : $unsigned(r_sd2);
        mr3    = (m3 + HALF) >> F;
        v3     = W'(mr3);
        if (mr3 > (neg3 ? DW'(MINN) : DW'(MAXP))) begin
            v3 = neg3 ? MINN : MAXP;
            if (r_ctl2.op == OP_DOT) begin
                n_res3.ovf = 1'b1;
            end
        end else if (neg3) begin
            v3 = -v3;
        end
        if (r_ctl2.op == OP_DOT) begin
            n_res3.sc = v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
            r_ctl3 <= '0;
        end else if (i_en) begin
            r_ctl1 <= '{valid: i_valid, op: t_op'(i_item.operation), zero: 1'b0};
            r_ctl2 <= r_ctl1;
            r_ctl3 <= '{valid: r_ctl2.valid, op: r_ctl2.op, zero: (r_sum2 == '0)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sgn1  <= n_sgn;
            r_prod1 <= n_prod;
            r_res1  <= n_res1;
            r_sum2  <= n_sum2;
            r_sd2   <= n_sd2;
            r_res2  <= r_res1;
            r_sum3  <= r_sum2;
            r_res3  <= n_res3;
        end
    end

    assign o_ctl = r_ctl3;
    assign o_sum = r_sum3;
    assign o_res = r_res3;

endmodule

@@ rtl/core/vgu_sqrt_cell.sv @@
// vgu_sqrt_cell: one root bit of a restoring square root, registered.
// Depends on vgu_pkg.
`timescale 1ns / 1ps

module vgu_sqrt_cell #(
    parameter int SW     = 66,
    parameter int RB     = 33,
    parameter int BIT    = 0,
    parameter int SIDE_W = 129
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  vgu_pkg::t_ctl     i_ctl,
    input  logic [SW-1:0]     i_rem,
    input  logic [RB-1:0]     i_root,
    input  logic [SIDE_W-1:0] i_side,
    output vgu_pkg::t_ctl     o_ctl,
    output logic [SW-1:0]     o_rem,
    output logic [RB-1:0]     o_root,
    output logic [SIDE_W-1:0] o_side
);
    import vgu_pkg::*;

    localparam logic [SW:0] ONE_SQ = {{SW{1'b0}}, 1'b1} << (2*BIT);

    logic [SW:0] trial;
    logic        take;

    // (root + 2^BIT)^2 - root^2 = root*2^(BIT+1) + 2^(2*BIT)
    assign trial = ((SW+1)'(i_root) << (BIT+1)) | ONE_SQ;
    assign take  = {1'b0, i_rem} >= trial;

    t_ctl r_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem  <= take ? SW'({1'b0, i_rem} - trial) : i_rem;
            o_root <= take ? (i_root | (RB'(1) << BIT)) : i_root;
            o_side <= i_side;
        end
    end

    assign o_ctl = r_ctl;

endmodule

@@ rtl/core/vgu_div_cell.sv @@
// vgu_div_cell: one quotient bit of three restoring dividers sharing a divisor.
// Depends on vgu_pkg.
`timescale 1ns / 1ps

module vgu_div_cell #(
    parameter int NW     = 51,
    parameter int DNW    = 35,
    parameter int QW     = 17,
    parameter int BIT    = 0,
    parameter int SIDE_W = 129
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  vgu_pkg::t_ctl        i_ctl,
    input  logic [2:0][NW-1:0]   i_rem,
    input  logic [2:0][QW-1:0]   i_q,
    input  logic [DNW-1:0]       i_den,
    input  logic [SIDE_W-1:0]    i_side,
    output vgu_pkg::t_ctl        o_ctl,
    output logic [2:0][NW-1:0]   o_rem,
    output logic [2:0][QW-1:0]   o_q,
    output logic [DNW-1:0]       o_den,
    output logic [SIDE_W-1:0]    o_side
);
    import vgu_pkg::*;

    logic [NW-1:0]      trial;
    logic [2:0][NW-1:0] n_rem;
    logic [2:0][QW-1:0] n_q;

    assign trial = NW'(i_den) << BIT;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            if (i_rem[j] >= trial) begin
                n_rem[j] = i_rem[j] - trial;
                n_q[j]   = i_q[j] | (QW'(1) << BIT);
            end else begin
                n_rem[j] = i_rem[j];
                n_q[j]   = i_q[j];
            end
        end
    end

    t_ctl r_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem  <= n_rem;
            o_q    <= n_q;
            o_den  <= i_den;
            o_side <= i_side;
        end
    end

    assign o_ctl = r_ctl;

endmodule

@@ rtl/core/vec3_geometry_unit.sv @@
// vec3_geometry_unit: top level of the 3D vector unit (normalize, subtract, dot, distance).
// Depends on vgu_pkg, vgu_front, vgu_sqrt_cell and vgu_div_cell.
`timescale 1ns / 1ps

// Usage:
//   Input channel: i_valid / i_item, stall back on o_stall. An item is taken
//   on a rising edge with i_valid high and o_stall low.
//   Output channel: o_valid / o_item, the receiver stalls with i_stall.
//   Every item gives exactly one result item, in order.
//   Pipeline stages, in order: three front stages, one square root cell per
//   root bit (COMP_WIDTH+1), a rounding stage, a divider setup stage, one
//   divider cell per quotient bit (FRAC_BITS+1) and the output register.
//   Throughput: one item per cycle while o_stall is low; every stage is a register,
//   so the chain holds up to COMP_WIDTH + FRAC_BITS + 8 items at once (56 at Q16.16).
//   Stall: while the output register holds a valid item and i_stall is high,
//   the whole chain freezes and o_stall goes high in the same cycle.
//   Reset (i_rst_n low, synchronous) clears every stage valid bit; data
//   registers are not reset.
//   Results saturate to the signed COMP_WIDTH range and set overflow.

module vec3_geometry_unit #(
    parameter int FRAC_BITS  = vgu_pkg::FRAC_BITS_DEF,
    parameter int COMP_WIDTH = vgu_pkg::COMP_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  vgu_pkg::t_in_item  i_item,
    output logic               o_stall,
    output logic               o_valid,
    output vgu_pkg::t_out_item o_item,
    input  logic               i_stall
);
    import vgu_pkg::*;

    localparam int W     = COMP_WIDTH;
    localparam int F     = FRAC_BITS;
    localparam int SW    = 2*W+2;        // sum of squares
    localparam int RB    = W+1;          // root bits
    localparam int LW    = RB+1;         // rounded root
    localparam int DNW   = LW+1;         // divisor 2*len
    localparam int NW    = W+F+3;        // dividend
    localparam int QW    = F+1;          // quotient never exceeds 2^F
    localparam int RES_W = 4*W+1;
    localparam int XW    = (QW > W) ? QW : W;
    localparam logic [W-1:0] MAXP = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINN = {1'b1, {(W-1){1'b0}}};

    typedef struct packed {
        logic [2:0][W-1:0] r;
        logic [W-1:0]      sc;
        logic              ovf;
    } t_res;

    // one global advance: the chain moves unless the output item is stuck
    logic en;
    logic r_out_valid;
    t_out_item r_out_item;

    assign en      = !(r_out_valid && i_stall);
    assign o_stall = !en;

    // ---------------- front: products and sums
    t_ctl             fr_ctl;
    logic [SW-1:0]    fr_sum;
    logic [RES_W-1:0] fr_res;

    vgu_front #(
        .FRAC_BITS (F),
        .COMP_WIDTH(W)
    ) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_valid(i_valid),
        .i_item (i_item),
        .o_ctl  (fr_ctl),
        .o_sum  (fr_sum),
        .o_res  (fr_res)
    );

    // ---------------- square root chain, MSB first
    t_ctl             sq_ctl  [RB+1];
    logic [SW-1:0]    sq_rem  [RB+1];
    logic [RB-1:0]    sq_root [RB+1];
    logic [RES_W-1:0] sq_res  [RB+1];

    assign sq_ctl[0]  = fr_ctl;
    assign sq_rem[0]  = fr_sum;
    assign sq_root[0] = '0;
    assign sq_res[0]  = fr_res;

    for (genvar g = 0; g < RB; g++) begin : g_sqrt
        vgu_sqrt_cell #(
            .SW    (SW),
            .RB    (RB),
            .BIT   (RB-1-g),
            .SIDE_W(RES_W)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_ctl  (sq_ctl[g]),
            .i_rem  (sq_rem[g]),
            .i_root (sq_root[g]),
            .i_side (sq_res[g]),
            .o_ctl  (sq_ctl[g+1]),
            .o_rem  (sq_rem[g+1]),
            .o_root (sq_root[g+1]),
            .o_side (sq_res[g+1])
        );
    end

    // ---------------- round to nearest; distance result
    t_ctl          r_rd_ctl;
    logic [LW-1:0] r_rd_len, n_len;
    t_res          r_rd_res, n_rd_res;

    always_comb begin
        // remainder above root means the true root is past root + 1/2
        n_len    = LW'(sq_root[RB]) + LW'(sq_rem[RB] > SW'(sq_root[RB]));
        n_rd_res = sq_res[RB];
        if (sq_ctl[RB].op == OP_DIST) begin
            if (n_len > LW'(MAXP)) begin
                n_rd_res.sc  = MAXP;
                n_rd_res.ovf = 1'b1;
            end else begin
                n_rd_res.sc = W'(n_len);
            end
        end
    end

    // ---------------- divider setup: (2*|a|*2^F + len) / (2*len)
    t_ctl               r_su_ctl;
    logic [2:0][NW-1:0] r_su_rem, n_su_rem;
    logic [DNW-1:0]     r_su_den;
    t_res               r_su_res;
    logic [W-1:0]       ma;

    always_comb begin
        ma = '0;
        for (int j = 0; j < 3; j++) begin
            ma = r_rd_res.r[j][W-1] ? -r_rd_res.r[j] : r_rd_res.r[j];
            n_su_rem[j] = (NW'(ma) << (F+1)) + NW'(r_rd_len);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ctl <= '0;
            r_su_ctl <= '0;
        end else if (en) begin
            r_rd_ctl <= sq_ctl[RB];
            r_su_ctl <= r_rd_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rd_len <= n_len;
            r_rd_res <= n_rd_res;
            r_su_rem <= n_su_rem;
            r_su_den <= {r_rd_len, 1'b0};
            r_su_res <= r_rd_res;
        end
    end

    // ---------------- divider chain, three lanes per cell
    t_ctl               dv_ctl [QW+1];
    logic [2:0][NW-1:0] dv_rem [QW+1];
    logic [2:0][QW-1:0] dv_q   [QW+1];
    logic [DNW-1:0]     dv_den [QW+1];
    logic [RES_W-1:0]   dv_res [QW+1];

    assign dv_ctl[0] = r_su_ctl;
    assign dv_rem[0] = r_su_rem;
    assign dv_q[0]   = '0;
    assign dv_den[0] = r_su_den;
    assign dv_res[0] = r_su_res;

    for (genvar g = 0; g < QW; g++) begin : g_div
        vgu_div_cell #(
            .NW    (NW),
            .DNW   (DNW),
            .QW    (QW),
            .BIT   (QW-1-g),
            .SIDE_W(RES_W)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_ctl  (dv_ctl[g]),
            .i_rem  (dv_rem[g]),
            .i_q    (dv_q[g]),
            .i_den  (dv_den[g]),
            .i_side (dv_res[g]),
            .o_ctl  (dv_ctl[g+1]),
            .o_rem  (dv_rem[g+1]),
            .o_q    (dv_q[g+1]),
            .o_den  (dv_den[g+1]),
            .o_side (dv_res[g+1])
        );
    end

    // ---------------- normalize clamp and output register
    t_res          fin;
    logic          neg;
    logic [XW-1:0] qx;
    logic [W-1:0]  v;

    always_comb begin
        fin = dv_res[QW];
        neg = 1'b0;
        qx  = '0;
        v   = '0;
        // zero length keeps a as it came in
        if (dv_ctl[QW].op == OP_NORM && !dv_ctl[QW].zero) begin
            for (int j = 0; j < 3; j++) begin
                neg = fin.r[j][W-1];
                qx  = XW'(dv_q[QW][j]);
                if (qx > (neg ? XW'(MINN) : XW'(MAXP))) begin
                    v       = neg ? MINN : MAXP;
                    fin.ovf = 1'b1;
                end else begin
                    v = W'(qx);
                    if (neg) begin
                        v = -v;
                    end
                end
                fin.r[j] = v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= dv_ctl[QW].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_item.rx       <= FIELD_W'($signed(fin.r[0]));
            r_out_item.ry       <= FIELD_W'($signed(fin.r[1]));
            r_out_item.rz       <= FIELD_W'($signed(fin.r[2]));
            r_out_item.scalar   <= FIELD_W'($signed(fin.sc));
            r_out_item.overflow <= fin.ovf;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;

endmodule

@@ rtl/core/vgu_checker.sv @@
// vgu_checker: port-level assertions for vec3_geometry_unit, bound to the top.
// Depends on vgu_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vgu_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_stall,
    input logic               i_out_valid,
    input vgu_pkg::t_out_item i_out_item,
    input logic               i_out_stall
);
    import vgu_pkg::*;

    // held output item stays put
    `ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && i_out_stall, i_out_valid)
    `ASSERT_NXT(a_out_stable, i_clk, i_rst_n, i_out_valid && i_out_stall, $stable(i_out_item))
    // the input side backs up exactly when the output item is stuck
    `ASSERT_IMP(a_bp, i_clk, i_rst_n, 1'b1, i_in_stall == (i_out_valid && i_out_stall))
    // scalar and vector results never appear together
    `ASSERT_IMP(a_excl, i_clk, i_rst_n, i_out_valid && (i_out_item.scalar != 0), (i_out_item.rx == 0) && (i_out_item.ry == 0) && (i_out_item.rz == 0))

endmodule

bind vec3_geometry_unit vgu_checker u_vgu_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_stall (o_stall),
    .i_out_valid(o_valid),
    .i_out_item (o_item),
    .i_out_stall(i_stall)
);
